// ----- hw/rtl/timed_release_backoff_queue_unit_defines.svh -----
`ifndef TIMED_RELEASE_BACKOFF_QUEUE_UNIT_DEFINES_SVH
`define TIMED_RELEASE_BACKOFF_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and skipped while rst_n is low.
`define TRBQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and skipped while rst_n is low.
`define TRBQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/trbq_pkg.sv -----
`default_nettype none

package trbq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int NXT_W = CNT_W + 1;
  localparam int TIME_W = 48;
  localparam int ID_W = 64;
  localparam int PEN_W = 32;
  localparam int SHIFT_W = 6;

  // One held entry as it sits in the entry memory.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] deadline;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_RELEASED = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_REJECTED = 2'd2
  } status_t;

  typedef enum logic {
    MODE_ENQ  = 1'b0,
    MODE_TICK = 1'b1
  } mode_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_BASE    = 2'd0;
  localparam logic [1:0] REG_MAX     = 2'd1;
  localparam logic [1:0] REG_BACKOFF = 2'd2;

endpackage

`default_nettype wire

// ----- hw/rtl/trbq_ram.sv -----
`default_nettype none

module trbq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 112
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/trbq_penalty.sv -----
`default_nettype none

module trbq_penalty (
  input  wire logic                          clk,
  input  wire logic [trbq_pkg::PEN_W-1:0]    base_penalty,
  input  wire logic [trbq_pkg::PEN_W-1:0]    max_penalty,
  input  wire logic                          backoff_enable,
  input  wire logic [trbq_pkg::SHIFT_W-1:0]  abort_count,
  output logic      [trbq_pkg::PEN_W-1:0]    penalty_r
);
  import trbq_pkg::*;

  logic [2*PEN_W-1:0] scaled;
  logic [PEN_W-1:0]   penalty_nxt;

  // With backoff enabled, the base shifted by the abort count and capped at the maximum; else the base.
  always_comb begin
    scaled = {{PEN_W{1'b0}}, base_penalty} << abort_count[4:0];
    if (!backoff_enable) begin
      penalty_nxt = base_penalty;
    end else if (base_penalty == '0) begin
      penalty_nxt = '0;
    end else if (abort_count[5]) begin
      penalty_nxt = max_penalty;
    end else if (scaled > {{PEN_W{1'b0}}, max_penalty}) begin
      penalty_nxt = max_penalty;
    end else begin
      penalty_nxt = scaled[PEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    penalty_r <= penalty_nxt;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/timed_release_backoff_queue_unit.sv -----
// Enqueue: the penalty and the deadline are worked out, then held entries with a later
// deadline are moved up one slot from the tail and the word is written in its place; a
// full queue rejects the word without touching the memory. Tick: the time advances, due
// entries are released from the head, then, when something was released, the rest are compacted.
// One item is in work at a time, using the sorted entry memory with its single write port
// and registered read. A word waiting in the result register holds the sequencer until it
// is taken.
// Reset (rst_n low, synchronous) empties the queue, zeroes the time and loads the register
// defaults; the entry memory is not cleared, since only entries below the count are read.
`default_nettype none
`include "timed_release_backoff_queue_unit_defines.svh"

module timed_release_backoff_queue_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // [63:0] txn_id, [69:64] abort_count, rest zero
  input  wire logic [0:0]  in_tuser,   // [0] mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [63:0] released_id
  output logic [1:0]       out_tuser,  // [1:0] status
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import trbq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PEN, S_DL, S_INS, S_INS_CMP, S_INS_PUT, S_RESP,
    S_REL, S_REL_CHK, S_REL_FLUSH, S_CMP_RD, S_CMP_WR
  } state_t;

  state_t              state_r, state_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [SHIFT_W-1:0]  shift_r, shift_nxt;
  logic [TIME_W-1:0]   dl_r, dl_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [CNT_W-1:0]    s_r, s_nxt;
  logic [ID_W-1:0]     pend_r, pend_nxt;
  logic                have_pend_r, have_pend_nxt;
  status_t             resp_r, resp_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  status_t             out_stat_r, out_stat_nxt;
  logic                out_last_r, out_last_nxt;
  logic [PEN_W-1:0]    base_r, max_r;
  logic                backoff_r;

  logic [PEN_W-1:0]    penalty;
  logic [TIME_W:0]     dl_sum;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  entry_t              ram_wdata, rd;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic                can_load, due, more, cfg_wr;
  logic [NXT_W-1:0]    n_inc, s_inc;
  logic [CNT_W-1:0]    s_dst;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // Register read-back.
  always_comb begin
    case (cfg_paddr[3:2])
      REG_BASE:    cfg_prdata = base_r;
      REG_MAX:     cfg_prdata = max_r;
      REG_BACKOFF: cfg_prdata = {31'd0, backoff_r};
      default:     cfg_prdata = '0;
    endcase
  end

  trbq_penalty u_pen (
    .clk            (clk),
    .base_penalty   (base_r),
    .max_penalty    (max_r),
    .backoff_enable (backoff_r),
    .abort_count    (shift_r),
    .penalty_r      (penalty)
  );

  trbq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ENTRY_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd       = entry_t'(ram_rdata);
  assign can_load = !out_valid_r || out_tready;
  assign dl_sum   = {1'b0, now_r} + {{(TIME_W+1-PEN_W){1'b0}}, penalty};
  assign due      = rd.deadline < now_r;
  assign n_inc    = {1'b0, n_r} + NXT_W'(1);
  assign s_inc    = {1'b0, s_r} + NXT_W'(1);
  assign more     = (n_inc < {1'b0, count_r}) && (n_inc < NXT_W'(MAX_RESULTS));
  assign s_dst    = s_r - n_r;

  // Sequencer: insertion sort on enqueue, head release and compaction on tick.
  always_comb begin
    state_nxt     = state_r;
    id_nxt        = id_r;
    shift_nxt     = shift_r;
    dl_nxt        = dl_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    s_nxt         = s_r;
    pend_nxt      = pend_r;
    have_pend_nxt = have_pend_r;
    resp_nxt      = resp_r;
    count_nxt     = count_r;
    now_nxt       = now_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_id_nxt    = out_id_r;
    out_stat_nxt  = out_stat_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '{id: id_r, deadline: dl_r};
    ram_raddr     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (mode_t'(in_tuser[0]) == MODE_ENQ) begin
            id_nxt    = in_tdata[63:0];
            shift_nxt = in_tdata[69:64];
            if (count_r == CNT_W'(QUEUE_DEPTH)) begin
              resp_nxt  = ST_REJECTED;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_PEN;
            end
          end else begin
            if (now_r != {TIME_W{1'b1}}) begin
              now_nxt = now_r + TIME_W'(1);
            end
            n_nxt         = '0;
            have_pend_nxt = 1'b0;
            state_nxt     = S_REL;
          end
        end
      end
      S_PEN: begin
        state_nxt = S_DL;
      end
      S_DL: begin
        dl_nxt    = dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];
        state_nxt = S_INS;
      end
      S_INS: begin
        if (count_r == '0) begin
          ram_we    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          resp_nxt  = ST_ACCEPTED;
          state_nxt = S_RESP;
        end else begin
          ram_raddr = IDX_W'(count_r - CNT_W'(1));
          k_nxt     = count_r;
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = k_r[IDX_W-1:0];
        if (rd.deadline > dl_r) begin
          ram_wdata = rd;
          k_nxt     = k_r - CNT_W'(1);
          if (k_r == CNT_W'(1)) begin
            state_nxt = S_INS_PUT;
          end else begin
            ram_raddr = IDX_W'(k_r - CNT_W'(2));
          end
        end else begin
          count_nxt = count_r + CNT_W'(1);
          resp_nxt  = ST_ACCEPTED;
          state_nxt = S_RESP;
        end
      end
      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = k_r[IDX_W-1:0];
        count_nxt = count_r + CNT_W'(1);
        resp_nxt  = ST_ACCEPTED;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = id_r;
          out_stat_nxt  = resp_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_REL: begin
        if (count_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_REL_CHK;
        end
      end
      S_REL_CHK: begin
        // The pending word goes out once the next entry shows whether it is the last.
        ram_raddr = n_r[IDX_W-1:0];
        if (!(have_pend_r && !can_load)) begin
          if (have_pend_r) begin
            out_valid_nxt = 1'b1;
            out_id_nxt    = pend_r;
            out_stat_nxt  = ST_RELEASED;
            out_last_nxt  = !due;
          end
          if (due) begin
            pend_nxt      = rd.id;
            have_pend_nxt = 1'b1;
            n_nxt         = n_inc[CNT_W-1:0];
            if (more) begin
              ram_raddr = n_inc[IDX_W-1:0];
            end else begin
              state_nxt = S_REL_FLUSH;
            end
          end else begin
            have_pend_nxt = 1'b0;
            state_nxt     = (n_r == '0) ? S_IDLE : S_CMP_RD;
          end
        end
      end
      S_REL_FLUSH: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = pend_r;
          out_stat_nxt  = ST_RELEASED;
          out_last_nxt  = 1'b1;
          have_pend_nxt = 1'b0;
          state_nxt     = S_CMP_RD;
        end
      end
      S_CMP_RD: begin
        if (n_r >= count_r) begin
          count_nxt = count_r - n_r;
          state_nxt = S_IDLE;
        end else begin
          ram_raddr = n_r[IDX_W-1:0];
          s_nxt     = n_r;
          state_nxt = S_CMP_WR;
        end
      end
      S_CMP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = s_dst[IDX_W-1:0];
        ram_wdata = rd;
        if (s_inc < {1'b0, count_r}) begin
          ram_raddr = s_inc[IDX_W-1:0];
          s_nxt     = s_inc[CNT_W-1:0];
        end else begin
          count_nxt = count_r - n_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, configuration and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      now_r       <= '0;
      have_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      base_r      <= PEN_W'(1000);
      max_r       <= PEN_W'(1000000);
      backoff_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      now_r       <= now_nxt;
      have_pend_r <= have_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          REG_BASE:    base_r    <= cfg_pwdata;
          REG_MAX:     max_r     <= cfg_pwdata;
          REG_BACKOFF: backoff_r <= cfg_pwdata[0];
          default:     ;
        endcase
      end
    end
    id_r       <= id_nxt;
    shift_r    <= shift_nxt;
    dl_r       <= dl_nxt;
    k_r        <= k_nxt;
    n_r        <= n_nxt;
    s_r        <= s_nxt;
    pend_r     <= pend_nxt;
    resp_r     <= resp_nxt;
    out_id_r   <= out_id_nxt;
    out_stat_r <= out_stat_nxt;
    out_last_r <= out_last_nxt;
  end

  `TRBQ_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH), "held count above depth")
  `TRBQ_ASSERT_IMP(a_no_write_idle, state_r == S_IDLE, !ram_we, "memory written while idle")
  `TRBQ_ASSERT_IMP(a_enq_last, out_valid_r && out_stat_r != ST_RELEASED, out_last_r,
    "enqueue answer not marked last")
  `TRBQ_ASSERT_NXT(a_time_mono, 1'b1, now_r >= $past(now_r) || !$past(rst_n),
    "time went backwards")

endmodule

`default_nettype wire

// ----- tb/tb_timed_release_backoff_queue_unit.sv -----
`timescale 1ns / 100ps
`default_nettype none

module tb_timed_release_backoff_queue_unit;
  import trbq_pkg::*;

  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    mode_t       mode;
    logic [63:0] txn_id;
    logic [5:0]  abort_count;
  } request_t;

  typedef struct packed {
    logic [63:0] released_id;
    status_t     status;
    logic        last;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  timed_release_backoff_queue_unit DUT (.*);

  // Predictor state: the held entries in release order, the clock and the registers.
  logic [63:0] held_ids[$];
  logic [47:0] held_deadlines[$];
  logic [47:0] now_ticks;
  logic [31:0] base_penalty;
  logic [31:0] max_penalty;
  logic        backoff_enable;

  request_t pending_words[$];
  answer_t  expected_answers[$];
  int       send_idle_pct;
  int       recv_idle_pct;
  bit       failed;
  int       cycle_count;
  bit       in_accepted;

  // Clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [47:0] deadline_for(logic [5:0] shift);
    logic [63:0] pen;
    logic [48:0] sum;
    if (!backoff_enable) begin
      pen = base_penalty;
    end else if (base_penalty == 0) begin
      pen = 0;
    end else if (shift >= 32) begin
      pen = max_penalty;
    end else begin
      pen = 64'(base_penalty) << shift;
      if (pen > max_penalty) pen = max_penalty;
    end
    sum = 49'(now_ticks) + 49'(pen);
    return (sum > 49'(TIME_MAX)) ? TIME_MAX : sum[47:0];
  endfunction

  // Works out the answers caused by one accepted word.
  task automatic predict_answers(request_t w);
    logic [47:0] dl;
    int          pos;
    int          n;
    answer_t     a;
    if (w.mode == MODE_ENQ) begin
      a.released_id = w.txn_id;
      a.last = 1'b1;
      if (held_ids.size() >= QUEUE_DEPTH) begin
        a.status = ST_REJECTED;
      end else begin
        dl = deadline_for(w.abort_count);
        pos = held_ids.size();
        while (pos > 0 && held_deadlines[pos-1] > dl) pos--;
        held_ids.insert(pos, w.txn_id);
        held_deadlines.insert(pos, dl);
        a.status = ST_ACCEPTED;
      end
      expected_answers.push_back(a);
    end else begin
      if (now_ticks < TIME_MAX) now_ticks++;
      n = 0;
      while (held_ids.size() > 0 && n < MAX_RESULTS && held_deadlines[0] < now_ticks) begin
        a.released_id = held_ids.pop_front();
        void'(held_deadlines.pop_front());
        a.status = ST_RELEASED;
        a.last = 1'b0;
        expected_answers.push_back(a);
        n++;
      end
      if (n > 0) expected_answers[expected_answers.size()-1].last = 1'b1;
    end
  endtask

  // Driver: offers pending words with random gaps and drives out_tready at random.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_accepted) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tuser  <= pending_words[0].mode;
          in_tdata  <= {2'b00, pending_words[0].abort_count, pending_words[0].txn_id};
          void'(pending_words.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts on accepted input words and checks each result word.
  always @(posedge clk) begin
    request_t w;
    answer_t  e;
    in_accepted = rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        w.mode = mode_t'(in_tuser[0]);
        w.txn_id = in_tdata[63:0];
        w.abort_count = in_tdata[69:64];
        predict_answers(w);
      end
      if (out_tvalid && out_tready) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected word id=%h status=%0d last=%b", $time,
                   out_tdata, out_tuser, out_tlast);
          failed = 1'b1;
        end else begin
          e = expected_answers.pop_front();
          if (out_tdata !== e.released_id || out_tuser !== e.status || out_tlast !== e.last) begin
            $display("%0t: mismatch expected id=%h status=%0d last=%b, actual id=%h status=%0d last=%b",
                     $time, e.released_id, e.status, e.last, out_tdata, out_tuser, out_tlast);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** timed_release_backoff_queue_unit: FAILED **");
      $finish;
    end
  end

  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_BASE:    base_penalty = value;
      REG_MAX:     max_penalty = value;
      REG_BACKOFF: backoff_enable = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_tvalid || expected_answers.size() > 0)
      @(posedge clk);
    // A tick that released entries may still be compacting after its last word.
    repeat (40) @(posedge clk);
  endtask

  task automatic add_word(mode_t m, logic [63:0] id, logic [5:0] sh);
    request_t w;
    w.mode = m;
    w.txn_id = id;
    w.abort_count = sh;
    pending_words.push_back(w);
  endtask

  function automatic logic [63:0] random_id();
    return {$urandom, $urandom};
  endfunction

  // A burst of enqueues followed by a run of ticks.
  task automatic add_burst(int count, int ticks);
    for (int i = 0; i < count; i++)
      add_word(MODE_ENQ, random_id(), 6'($urandom_range(63)));
    for (int i = 0; i < ticks; i++)
      add_word(MODE_TICK, random_id(), 6'($urandom_range(63)));
  endtask

  task automatic random_phase(int items);
    int made;
    made = 0;
    while (made < items) begin
      int c, t;
      c = $urandom_range(1, 8);
      t = $urandom_range(1, 6);
      add_burst(c, t);
      made += c + t;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    failed = 1'b0;
    cycle_count = 0;
    send_idle_pct = 22;
    recv_idle_pct = 80;
    now_ticks = '0;
    base_penalty = 32'd1000;
    max_penalty = 32'd1000000;
    backoff_enable = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero penalty so entries release on the next tick, id extremes,
    // a full queue rejection, as many as the per-tick release limit, tick with nothing due.
    write_register(REG_BASE, 32'd0);
    add_word(MODE_TICK, 64'd0, 6'd0);
    add_word(MODE_ENQ, 64'd0, 6'd0);
    add_word(MODE_ENQ, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63);
    for (int i = 0; i < 15; i++) add_word(MODE_ENQ, random_id(), 6'($urandom_range(63)));
    add_word(MODE_TICK, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63);
    add_word(MODE_TICK, 64'd0, 6'd0);
    add_word(MODE_TICK, 64'd0, 6'd0);
    wait_drained();

    // Backoff with small values; large shift hits the cap.
    write_register(REG_BASE, 32'd1);
    write_register(REG_MAX, 32'd5);
    write_register(REG_BACKOFF, 32'd1);
    add_word(MODE_ENQ, 64'h1, 6'd0);
    add_word(MODE_ENQ, 64'h2, 6'd1);
    add_word(MODE_ENQ, 64'h3, 6'd40);
    add_word(MODE_ENQ, 64'h4, 6'd2);
    for (int i = 0; i < 7; i++) add_word(MODE_TICK, 64'd0, 6'd0);
    random_phase(40);
    wait_drained();

    // Roles swap: the sender now idles often and the receiver rarely.
    send_idle_pct = 80;
    recv_idle_pct = 22;
    write_register(REG_BASE, 32'd3);
    write_register(REG_MAX, 32'd0);
    write_register(REG_BACKOFF, 32'd0);
    random_phase(40);
    wait_drained();

    // Huge penalty pushes the deadline far out; the entries stay held.
    write_register(REG_BASE, 32'hFFFF_FFFF);
    write_register(REG_MAX, 32'hFFFF_FFFF);
    write_register(REG_BACKOFF, 32'd1);
    add_word(MODE_ENQ, random_id(), 6'd31);
    add_word(MODE_ENQ, random_id(), 6'd16);
    add_word(MODE_TICK, 64'd0, 6'd0);
    wait_drained();

    // No idling, modest backoff; extra ticks release what falls due.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_register(REG_BASE, 32'd1);
    write_register(REG_MAX, 32'd8);
    random_phase(30);
    for (int i = 0; i < 10; i++) add_word(MODE_TICK, random_id(), 6'($urandom_range(63)));
    wait_drained();

    if (!failed) begin
      $display("** timed_release_backoff_queue_unit: PASSED **");
    end else begin
      $display("** timed_release_backoff_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
